### rtl/atsmp_pkg.sv
// Shared types, widths and codes for the alias table sampler.
package atsmp_pkg;

  localparam int MAX_ENTRIES_DEF   = 256;
  localparam int FRACTION_BITS_DEF = 24;
  localparam int Q24_BITS          = 24;
  localparam int WEIGHT_W          = 32;
  localparam int INDEX_W           = 8;
  localparam int PMF_W             = 25;

  typedef enum logic [1:0] {
    ST_SAMPLE = 2'd0,
    ST_STORED = 2'd1,
    ST_BUILT  = 2'd2,
    ST_ERROR  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_LOAD,
    OP_B_INIT,
    OP_B_READ,
    OP_B_DIV,
    OP_B_MUL,
    OP_B_WRITE,
    OP_P_POP,
    OP_P_RDLO,
    OP_P_RDHI,
    OP_P_WRITE,
    OP_S_MUL,
    OP_S_COL,
    OP_S_READ,
    OP_S_CMP,
    OP_S_REM,
    OP_S_PMF,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic last;
    logic full;
    logic can_sample;
    logic div_done;
    logic build_end;
    logic pair_ok;
    logic need_div;
  } dp_stat_t;

endpackage

### rtl/atsmp_divider.sv
// Restoring fractional divider: floor(a * 2^F / d) for a <= d, one bit per cycle.
module atsmp_divider import atsmp_pkg::*; #(
  parameter int DV_W = 40,
  parameter int F    = FRACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DV_W-1:0] dividend,
  input  logic [DV_W-1:0] divisor,
  output logic            done,
  output logic [F:0]      quotient
);

  localparam int CW = $clog2(F + 1);

  logic [DV_W-1:0] rem_r;
  logic [DV_W-1:0] div_r;
  logic [F:0]      quo_r;
  logic [CW-1:0]   cnt_r;
  logic            run_r;
  logic            done_r;
  logic [DV_W:0]   rem2;
  logic            ge;
  logic            q0;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, div_r};
  assign q0   = dividend >= divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(F);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= q0 ? dividend - divisor : dividend;
      quo_r <= {{F{1'b0}}, q0};
    end else if (run_r) begin
      rem_r <= ge ? DV_W'(rem2 - {1'b0, div_r}) : DV_W'(rem2);
      quo_r <= {quo_r[F-1:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/atsmp_datapath.sv
// Datapath: weight and table memories, stacks, counters, divider and result registers.
module atsmp_datapath import atsmp_pkg::*; #(
  parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 start,
  input  logic                 in_command,
  input  logic [WEIGHT_W-1:0]  in_weight,
  input  logic                 in_last_weight,
  input  logic [Q24_BITS-1:0]  in_uniform_sample,
  output logic                 out_strobe,
  output logic [1:0]           out_status,
  output logic [INDEX_W-1:0]   out_chosen_index,
  output logic [PMF_W-1:0]     out_chosen_pmf,
  output logic [Q24_BITS-1:0]  out_remapped_sample
);

  localparam int F     = FRACTION_BITS;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int PW    = F + 1;
  localparam int SC_W  = PW + CNT_W;
  localparam int TOT_W = WEIGHT_W + CNT_W;
  localparam int PR_W  = F + CNT_W;
  localparam int UW    = Q24_BITS + F;
  localparam int OW    = PW + Q24_BITS;
  localparam logic [PW-1:0]   ONE_P  = {1'b1, {F{1'b0}}};
  localparam logic [SC_W-1:0] ONE_SC = {{(SC_W - PW){1'b0}}, ONE_P};

  // Storage whose contents are defined by the loads and the build before any read.
  logic [WEIGHT_W-1:0] weight_mem [MAX_ENTRIES];
  logic [PW-1:0]       pmf_mem    [MAX_ENTRIES];
  logic [SC_W-1:0]     scaled_mem [MAX_ENTRIES];
  logic [PW-1:0]       prob_mem   [MAX_ENTRIES];
  logic [IDX_W-1:0]    alias_mem  [MAX_ENTRIES];
  logic [IDX_W-1:0]    small_mem  [MAX_ENTRIES];
  logic [IDX_W-1:0]    large_mem  [MAX_ENTRIES];

  // Control state.
  logic [CNT_W-1:0] count_r;
  logic [TOT_W-1:0] total_r;
  logic             ready_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] ns_r;
  logic [CNT_W-1:0] nl_r;
  logic             out_strobe_r;

  // Item and working registers.
  logic                command_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic                last_r;
  logic [Q24_BITS-1:0] uniform_r;
  logic [WEIGHT_W-1:0] weight_q;
  logic [PW-1:0]       pmf_r;
  logic [SC_W-1:0]     sc_r;
  logic [IDX_W-1:0]    small_q;
  logic [IDX_W-1:0]    large_q;
  logic [SC_W-1:0]     scaled_q;
  logic [IDX_W-1:0]    lo_r;
  logic [IDX_W-1:0]    hi_r;
  logic [SC_W-1:0]     slo_r;
  logic [PR_W-1:0]     prod_r;
  logic [IDX_W-1:0]    col_r;
  logic [F-1:0]        frac_r;
  logic [PW-1:0]       prob_q;
  logic [IDX_W-1:0]    alias_q;
  logic [IDX_W-1:0]    index_r;
  logic                nd_r;
  logic [F-1:0]        rem_r;
  logic [PW-1:0]       pmf_q;
  logic [1:0]          out_status_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic [PMF_W-1:0]    out_pmf_r;
  logic [Q24_BITS-1:0] out_rem_r;

  logic [CNT_W-1:0] eff_count;
  logic [TOT_W-1:0] eff_total;
  logic             full;
  logic [IDX_W-1:0] idx_a;
  logic             sc_small;
  logic [SC_W-1:0]  new_sc;
  logic             new_small;
  logic [F-1:0]     fu;
  logic [CNT_W-1:0] colw;
  logic [CNT_W-1:0] col_cl;
  logic             lt;
  logic             prob_one;
  logic             need_div;
  logic [IDX_W-1:0] pick;
  logic [IDX_W-1:0] pick_cl;
  logic [CNT_W-1:0] last_idx;
  logic             div_start;
  logic [TOT_W-1:0] div_a;
  logic [TOT_W-1:0] div_d;
  logic             div_done;
  logic [F:0]       div_q;
  logic [F-1:0]     frac_m_prob;
  logic [PW-1:0]    one_m_prob;

  assign eff_count = ready_r ? '0 : count_r;
  assign eff_total = ready_r ? '0 : total_r;
  assign full      = eff_count == CNT_W'(MAX_ENTRIES);
  assign idx_a     = idx_r[IDX_W-1:0];
  assign last_idx  = count_r - 1'b1;
  assign sc_small  = sc_r < ONE_SC;
  assign new_sc    = scaled_q + slo_r - ONE_SC;
  assign new_small = new_sc < ONE_SC;

  // Q0.24 input to F fraction bits, floored.
  assign fu     = F'((UW'(uniform_r) << F) >> Q24_BITS);
  assign colw   = prod_r[PR_W-1:F];
  assign col_cl = (colw >= count_r) ? last_idx : colw;

  assign lt          = {1'b0, frac_r} < prob_q;
  assign prob_one    = prob_q == ONE_P;
  assign need_div    = lt || !prob_one;
  assign pick        = lt ? col_r : alias_q;
  assign pick_cl     = (CNT_W'(pick) >= count_r) ? last_idx[IDX_W-1:0] : pick;
  assign frac_m_prob = frac_r - prob_q[F-1:0];
  assign one_m_prob  = ONE_P - prob_q;

  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_d     = '0;
    case (cmd.op)
      OP_B_DIV: begin
        div_start = 1'b1;
        if (total_r != '0) begin
          div_a = TOT_W'(weight_q);
          div_d = total_r;
        end else begin
          div_a = TOT_W'(1);
          div_d = TOT_W'(count_r);
        end
      end
      OP_S_CMP: begin
        div_start = need_div;
        div_a     = lt ? TOT_W'(frac_r) : TOT_W'(frac_m_prob);
        div_d     = lt ? TOT_W'(prob_q) : TOT_W'(one_m_prob);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  atsmp_divider #(
    .DV_W (TOT_W),
    .F    (F)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // Counters and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      total_r      <= '0;
      ready_r      <= 1'b0;
      idx_r        <= '0;
      ns_r         <= '0;
      nl_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.op == OP_EMIT;
      case (cmd.op)
        OP_LOAD: begin
          ready_r <= 1'b0;
          if (full) begin
            if (last_r) begin
              count_r <= '0;
              total_r <= '0;
            end
          end else begin
            count_r <= eff_count + 1'b1;
            total_r <= eff_total + TOT_W'(weight_r);
          end
        end
        OP_B_INIT: begin
          idx_r <= '0;
          ns_r  <= '0;
          nl_r  <= '0;
        end
        OP_B_WRITE: begin
          idx_r <= idx_r + 1'b1;
          if (sc_small) begin
            ns_r <= ns_r + 1'b1;
          end else begin
            nl_r <= nl_r + 1'b1;
          end
        end
        OP_P_POP: begin
          ns_r <= ns_r - 1'b1;
          nl_r <= nl_r - 1'b1;
        end
        OP_P_WRITE: begin
          if (new_small) begin
            ns_r <= ns_r + 1'b1;
          end else begin
            nl_r <= nl_r + 1'b1;
          end
        end
        OP_EMIT: begin
          if (cmd.code == ST_BUILT) begin
            ready_r <= 1'b1;
          end
        end
        default: begin
          ready_r <= ready_r;
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE && start) begin
      command_r <= in_command;
      weight_r  <= in_weight;
      last_r    <= in_last_weight;
      uniform_r <= in_uniform_sample;
    end
    if (cmd.op == OP_B_MUL) begin
      pmf_r <= div_q;
      sc_r  <= SC_W'(div_q) * SC_W'(count_r);
    end
    if (cmd.op == OP_P_RDLO) begin
      lo_r <= small_q;
      hi_r <= large_q;
    end
    if (cmd.op == OP_P_RDHI) begin
      slo_r <= scaled_q;
    end
    if (cmd.op == OP_S_MUL) begin
      prod_r <= PR_W'(fu) * PR_W'(count_r);
    end
    if (cmd.op == OP_S_COL) begin
      col_r  <= col_cl[IDX_W-1:0];
      frac_r <= prod_r[F-1:0];
    end
    if (cmd.op == OP_S_CMP) begin
      index_r <= pick_cl;
      nd_r    <= need_div;
    end
    if (cmd.op == OP_S_REM) begin
      if (!nd_r) begin
        rem_r <= '0;
      end else if (div_q[F]) begin
        rem_r <= '1;
      end else begin
        rem_r <= div_q[F-1:0];
      end
    end
    if (cmd.op == OP_EMIT) begin
      out_status_r <= cmd.code;
      if (cmd.code == ST_SAMPLE) begin
        out_index_r <= INDEX_W'(index_r);
        out_pmf_r   <= PMF_W'((OW'(pmf_q) << Q24_BITS) >> F);
        out_rem_r   <= Q24_BITS'((OW'(rem_r) << Q24_BITS) >> F);
      end else begin
        out_index_r <= '0;
        out_pmf_r   <= '0;
        out_rem_r   <= '0;
      end
    end
  end

  // Weight memory.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && !full) begin
      weight_mem[eff_count[IDX_W-1:0]] <= weight_r;
    end
    if (cmd.op == OP_B_READ) begin
      weight_q <= weight_mem[idx_a];
    end
  end

  // Pmf memory.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_B_WRITE) begin
      pmf_mem[idx_a] <= pmf_r;
    end
    if (cmd.op == OP_S_PMF) begin
      pmf_q <= pmf_mem[index_r];
    end
  end

  // Scaled memory: written by the build; in pairing, read lo, then hi, then write back the large entry.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_B_WRITE) begin
      scaled_mem[idx_a] <= sc_r;
    end else if (cmd.op == OP_P_WRITE) begin
      scaled_mem[hi_r] <= new_sc;
    end
    if (cmd.op == OP_P_RDLO) begin
      scaled_q <= scaled_mem[small_q];
    end else if (cmd.op == OP_P_RDHI) begin
      scaled_q <= scaled_mem[hi_r];
    end
  end

  // Probability memory.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_B_WRITE) begin
      prob_mem[idx_a] <= ONE_P;
    end else if (cmd.op == OP_P_WRITE) begin
      prob_mem[lo_r] <= PW'(slo_r);
    end
    if (cmd.op == OP_S_READ) begin
      prob_q <= prob_mem[col_r];
    end
  end

  // Alias memory.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_B_WRITE) begin
      alias_mem[idx_a] <= idx_a;
    end else if (cmd.op == OP_P_WRITE) begin
      alias_mem[lo_r] <= hi_r;
    end
    if (cmd.op == OP_S_READ) begin
      alias_q <= alias_mem[col_r];
    end
  end

  // Small and large work stacks.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_B_WRITE && sc_small) begin
      small_mem[ns_r[IDX_W-1:0]] <= idx_a;
    end else if (cmd.op == OP_P_WRITE && new_small) begin
      small_mem[ns_r[IDX_W-1:0]] <= hi_r;
    end
    if (cmd.op == OP_P_POP) begin
      small_q <= small_mem[ns_r[IDX_W-1:0] - 1'b1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_B_WRITE && !sc_small) begin
      large_mem[nl_r[IDX_W-1:0]] <= idx_a;
    end else if (cmd.op == OP_P_WRITE && !new_small) begin
      large_mem[nl_r[IDX_W-1:0]] <= hi_r;
    end
    if (cmd.op == OP_P_POP) begin
      large_q <= large_mem[nl_r[IDX_W-1:0] - 1'b1];
    end
  end

  always_comb begin
    stat.is_sample  = command_r;
    stat.last       = last_r;
    stat.full       = full;
    stat.can_sample = ready_r && (count_r != '0);
    stat.div_done   = div_done;
    stat.build_end  = idx_r == last_idx;
    stat.pair_ok    = (ns_r != '0) && (nl_r != '0);
    stat.need_div   = need_div;
  end

  assign out_strobe          = out_strobe_r;
  assign out_status          = out_status_r;
  assign out_chosen_index    = out_index_r;
  assign out_chosen_pmf      = out_pmf_r;
  assign out_remapped_sample = out_rem_r;

endmodule

### rtl/atsmp_ctrl.sv
// Controller state machine that sequences loads, the table build and samples.
module atsmp_ctrl import atsmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_B_INIT,
    S_B_READ,
    S_B_DIV,
    S_B_WAIT,
    S_B_MUL,
    S_B_WRITE,
    S_P_CHECK,
    S_P_POP,
    S_P_RDLO,
    S_P_RDHI,
    S_P_WRITE,
    S_S_MUL,
    S_S_COL,
    S_S_READ,
    S_S_CMP,
    S_S_WAIT,
    S_S_REM,
    S_S_PMF,
    S_EMIT
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  logic    busy_r;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd.op    = OP_IDLE;
    cmd.code  = code_r;
    case (state_r)
      S_IDLE: begin
        cmd.op = OP_CAPTURE;
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_sample) begin
          cmd.op = OP_LOAD;
          if (stat.full) begin
            code_nxt  = ST_ERROR;
            state_nxt = S_EMIT;
          end else if (stat.last) begin
            state_nxt = S_B_INIT;
          end else begin
            code_nxt  = ST_STORED;
            state_nxt = S_EMIT;
          end
        end else if (stat.can_sample) begin
          state_nxt = S_S_MUL;
        end else begin
          code_nxt  = ST_ERROR;
          state_nxt = S_EMIT;
        end
      end
      S_B_INIT: begin
        cmd.op    = OP_B_INIT;
        state_nxt = S_B_READ;
      end
      S_B_READ: begin
        cmd.op    = OP_B_READ;
        state_nxt = S_B_DIV;
      end
      S_B_DIV: begin
        cmd.op    = OP_B_DIV;
        state_nxt = S_B_WAIT;
      end
      S_B_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_B_MUL;
        end
      end
      S_B_MUL: begin
        cmd.op    = OP_B_MUL;
        state_nxt = S_B_WRITE;
      end
      S_B_WRITE: begin
        cmd.op    = OP_B_WRITE;
        state_nxt = stat.build_end ? S_P_CHECK : S_B_READ;
      end
      S_P_CHECK: begin
        if (stat.pair_ok) begin
          state_nxt = S_P_POP;
        end else begin
          code_nxt  = ST_BUILT;
          state_nxt = S_EMIT;
        end
      end
      S_P_POP: begin
        cmd.op    = OP_P_POP;
        state_nxt = S_P_RDLO;
      end
      S_P_RDLO: begin
        cmd.op    = OP_P_RDLO;
        state_nxt = S_P_RDHI;
      end
      S_P_RDHI: begin
        cmd.op    = OP_P_RDHI;
        state_nxt = S_P_WRITE;
      end
      S_P_WRITE: begin
        cmd.op    = OP_P_WRITE;
        state_nxt = S_P_CHECK;
      end
      S_S_MUL: begin
        cmd.op    = OP_S_MUL;
        state_nxt = S_S_COL;
      end
      S_S_COL: begin
        cmd.op    = OP_S_COL;
        state_nxt = S_S_READ;
      end
      S_S_READ: begin
        cmd.op    = OP_S_READ;
        state_nxt = S_S_CMP;
      end
      S_S_CMP: begin
        cmd.op    = OP_S_CMP;
        state_nxt = stat.need_div ? S_S_WAIT : S_S_REM;
      end
      S_S_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_S_REM;
        end
      end
      S_S_REM: begin
        cmd.op    = OP_S_REM;
        state_nxt = S_S_PMF;
      end
      S_S_PMF: begin
        cmd.op    = OP_S_PMF;
        code_nxt  = ST_SAMPLE;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_ERROR;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      busy_r  <= state_nxt != S_IDLE;
    end
  end

  assign busy = busy_r;

endmodule

### rtl/alias_table_sampler.sv
// Sample: out_strobe follows the sample's steps, and the remap divide on the bit-serial divider is
// skipped when not needed. Plain load: decoded, then out_strobe. Last load builds the table: one
// divide per entry in the divide pass, then the small/large pairing pass, before out_strobe.
// One item at a time; start is taken while busy is low, also in the out_strobe cycle.
// Synchronous active-low reset empties the table; memories are not cleared.
module alias_table_sampler import atsmp_pkg::*; #(
  parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_command,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic                in_last_weight,
  input  logic [Q24_BITS-1:0] in_uniform_sample,
  output logic                out_strobe,
  output logic [1:0]          out_status,
  output logic [INDEX_W-1:0]  out_chosen_index,
  output logic [PMF_W-1:0]    out_chosen_pmf,
  output logic [Q24_BITS-1:0] out_remapped_sample
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  atsmp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  atsmp_datapath #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .start               (start),
    .in_command          (in_command),
    .in_weight           (in_weight),
    .in_last_weight      (in_last_weight),
    .in_uniform_sample   (in_uniform_sample),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_chosen_index    (out_chosen_index),
    .out_chosen_pmf      (out_chosen_pmf),
    .out_remapped_sample (out_remapped_sample)
  );

endmodule

### rtl/atsmp_checker.sv
// Port-level checks for the alias table sampler and the bind that attaches them.
module atsmp_checker import atsmp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input logic [1:0]          out_status,
  input logic [INDEX_W-1:0]  out_chosen_index,
  input logic [PMF_W-1:0]    out_chosen_pmf,
  input logic [Q24_BITS-1:0] out_remapped_sample
);

  // An accepted item makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted item");

  // A result closes the work of an item.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy) && !busy)
    else $error("result strobe outside the end of an item");

  // The result strobe drops again straight after each result.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // Items other than samples carry zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_SAMPLE) |->
      out_chosen_index == '0 && out_chosen_pmf == '0 && out_remapped_sample == '0)
    else $error("non-sample result with nonzero fields");

  // A probability never exceeds one.
  a_pmf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_chosen_pmf <= PMF_W'(1 << Q24_BITS))
    else $error("pmf above one");

endmodule

bind alias_table_sampler atsmp_checker u_atsmp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_status          (out_status),
  .out_chosen_index    (out_chosen_index),
  .out_chosen_pmf      (out_chosen_pmf),
  .out_remapped_sample (out_remapped_sample)
);

### dv/alias_table_sampler_chk.sv
// Checker that predicts alias table sampler results and compares them with the block's output.
`timescale 1ns / 100ps
module alias_table_sampler_chk import atsmp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_command,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic                in_last_weight,
  input  logic [Q24_BITS-1:0] in_uniform_sample,
  input  logic                out_strobe,
  input  logic [1:0]          out_status,
  input  logic [INDEX_W-1:0]  out_chosen_index,
  input  logic [PMF_W-1:0]    out_chosen_pmf,
  input  logic [Q24_BITS-1:0] out_remapped_sample,
  output int                  fail_count,
  output int                  pending_count,
  output int                  sample_count,
  output int                  build_count,
  output int                  error_count
);

  localparam int N_MAX = 256;
  localparam int FB = 24;
  localparam logic [63:0] ONE = 64'd1 << FB;

  typedef struct packed {
    status_t                status;
    logic [INDEX_W-1:0]     index;
    logic [PMF_W-1:0]       pmf;
    logic [Q24_BITS-1:0]    remap;
  } draw_result_t;

  draw_result_t expected_draws[$];

  logic [31:0] weights [N_MAX];
  logic [63:0] pmfs [N_MAX];
  logic [63:0] scaled [N_MAX];
  logic [63:0] probs [N_MAX];
  int          aliases [N_MAX];
  int          n_entries;
  logic [63:0] total;
  bit          ready;

  function automatic logic [63:0] fixed_ratio(logic [63:0] a, logic [63:0] d);
    logic [63:0] q, r;
    q = a / d;
    r = a % d;
    for (int k = 0; k < FB; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic void build_alias_table();
    int small_ids[N_MAX];
    int large_ids[N_MAX];
    int ns, nl;
    int lo, hi;
    ns = 0;
    nl = 0;
    for (int i = 0; i < n_entries; i++) begin
      pmfs[i] = (total != 0) ? fixed_ratio(64'(weights[i]), total)
                             : fixed_ratio(64'd1, 64'(n_entries));
      scaled[i] = pmfs[i] * 64'(n_entries);
      probs[i] = ONE;
      aliases[i] = i;
      if (scaled[i] < ONE) begin
        small_ids[ns] = i;
        ns++;
      end else begin
        large_ids[nl] = i;
        nl++;
      end
    end
    while (ns > 0 && nl > 0) begin
      ns--;
      nl--;
      lo = small_ids[ns];
      hi = large_ids[nl];
      probs[lo] = scaled[lo];
      aliases[lo] = hi;
      scaled[hi] = scaled[hi] + scaled[lo] - ONE;
      if (scaled[hi] < ONE) begin
        small_ids[ns] = hi;
        ns++;
      end else begin
        large_ids[nl] = hi;
        nl++;
      end
    end
  endfunction

  function automatic draw_result_t predict_draw(logic cmd, logic [31:0] w, logic lst,
                                                logic [23:0] u);
    draw_result_t res;
    logic [63:0] sc, col, frac, p, rem;
    int idx;
    res = '{ST_ERROR, '0, '0, '0};
    if (cmd == 1'b0) begin
      if (ready) begin
        ready = 0;
        n_entries = 0;
        total = 0;
      end
      if (n_entries >= N_MAX) begin
        if (lst) begin
          n_entries = 0;
          total = 0;
        end
        return res;
      end
      weights[n_entries] = w;
      n_entries++;
      total += 64'(w);
      if (lst) begin
        build_alias_table();
        ready = 1;
        res.status = ST_BUILT;
      end else begin
        res.status = ST_STORED;
      end
      return res;
    end
    if (!ready || n_entries == 0) return res;
    sc = 64'(u) * 64'(n_entries);
    col = sc >> FB;
    frac = sc & (ONE - 1);
    if (col >= 64'(n_entries)) col = 64'(n_entries - 1);
    p = probs[col];
    if (frac < p) begin
      idx = int'(col);
      rem = fixed_ratio(frac, p);
    end else begin
      idx = aliases[col];
      rem = (p < ONE) ? fixed_ratio(frac - p, ONE - p) : '0;
    end
    if (idx >= n_entries) idx = n_entries - 1;
    if (rem > ONE - 1) rem = ONE - 1;
    res.status = ST_SAMPLE;
    res.index = idx[7:0];
    res.pmf = pmfs[idx][PMF_W-1:0];
    res.remap = rem[23:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    draw_result_t want;
    if (!rst_n) begin
      n_entries = 0;
      total = 0;
      ready = 0;
      expected_draws.delete();
      pending_count <= 0;
    end else begin
      if (out_strobe) begin
        if (expected_draws.size() == 0) begin
          report_mismatch("unexpected result status", 64'(out_status), 64'd0);
        end else begin
          want = expected_draws.pop_front();
          if (out_status != want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_chosen_index != want.index)
            report_mismatch("index", 64'(out_chosen_index), 64'(want.index));
          if (out_chosen_pmf != want.pmf)
            report_mismatch("pmf", 64'(out_chosen_pmf), 64'(want.pmf));
          if (out_remapped_sample != want.remap)
            report_mismatch("remapped", 64'(out_remapped_sample), 64'(want.remap));
          case (want.status)
            ST_SAMPLE: sample_count++;
            ST_BUILT:  build_count++;
            ST_ERROR:  error_count++;
            default: ;
          endcase
        end
      end
      if (start && !busy)
        expected_draws.insert(expected_draws.size(),
                              predict_draw(in_command, in_weight, in_last_weight,
                                           in_uniform_sample));
      pending_count <= expected_draws.size();
    end
  end

  initial begin
    fail_count = 0;
    sample_count = 0;
    build_count = 0;
    error_count = 0;
  end

endmodule

### dv/alias_table_sampler_tb.sv
// Testbench top for the alias table sampler: stimulus, checker hookup and verdict.
`timescale 1ns / 100ps
module alias_table_sampler_tb import atsmp_pkg::*; ();

  localparam int CYCLE_LIMIT = 3_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_command = 1'b0;
  logic [WEIGHT_W-1:0] in_weight = '0;
  logic                in_last_weight = 1'b0;
  logic [Q24_BITS-1:0] in_uniform_sample = '0;
  logic                out_strobe;
  logic [1:0]          out_status;
  logic [INDEX_W-1:0]  out_chosen_index;
  logic [PMF_W-1:0]    out_chosen_pmf;
  logic [Q24_BITS-1:0] out_remapped_sample;
  int                  fail_count, pending_count, sample_count, build_count, error_count;
  int                  cycle_count = 0;
  int                  item_count = 0;
  bit                  calm_tail = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  alias_table_sampler uut (.*);

  alias_table_sampler_chk chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("alias_table_sampler_tb: done, errors");
      $finish;
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic issue(logic cmd, logic [31:0] w, logic lst, logic [23:0] u);
    int gap;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_weight <= w;
    in_last_weight <= lst;
    in_uniform_sample <= u;
    do @(posedge clk); while (busy);
    item_count++;
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_table(int n);
    for (int i = 0; i < n; i++) issue(1'b0, rand_weight(), i == n - 1, 24'($urandom));
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: sample with no table, zero-total table, extreme weights and samples.
    issue(1'b1, 32'hFFFF_FFFF, 1'b1, 24'hFFFFFF);
    issue(1'b0, 32'd0, 1'b0, 24'hFFFFFF);
    issue(1'b0, 32'd0, 1'b0, 24'd0);
    issue(1'b0, 32'd0, 1'b1, 24'd0);
    issue(1'b1, 32'd0, 1'b0, 24'd0);
    issue(1'b1, 32'd0, 1'b0, 24'hFFFFFF);
    issue(1'b0, 32'hFFFF_FFFF, 1'b0, 24'd0);
    issue(1'b0, 32'd1, 1'b0, 24'd0);
    issue(1'b0, 32'd0, 1'b1, 24'd0);
    issue(1'b1, 32'hFFFF_FFFF, 1'b1, 24'd0);
    issue(1'b1, 32'd0, 1'b0, 24'h800000);
    issue(1'b1, 32'd0, 1'b0, 24'hFFFFFF);
    issue(1'b0, 32'd5, 1'b1, 24'd0);
    issue(1'b1, 32'd0, 1'b0, 24'h123456);
    // Full table, then overflow weights and an abandoned sequence.
    for (int i = 0; i < 256; i++) issue(1'b0, $urandom, 1'b0, 24'($urandom));
    issue(1'b0, 32'hFFFF_FFFF, 1'b0, 24'd0);
    issue(1'b0, 32'd7, 1'b1, 24'd0);
    issue(1'b1, 32'd0, 1'b0, 24'hABCDEF);
    load_table(256);
    for (int i = 0; i < 40; i++) issue(1'b1, $urandom, 1'($urandom), 24'($urandom));
    // Random: mostly small tables followed by sample bursts, with some noise.
    while (item_count < 1650) begin
      if (item_count > 1450) calm_tail = 1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      load_table(n);
      repeat ($urandom_range(5, 30)) issue(1'b1, $urandom, 1'($urandom), 24'($urandom));
      if ($urandom_range(0, 7) == 0)
        issue(1'($urandom), $urandom, 1'($urandom), 24'($urandom));
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d items: %0d samples, %0d table builds, %0d error results",
             item_count, sample_count, build_count, error_count);
    if (fail_count == 0) $display("alias_table_sampler_tb: done, clean");
    else $display("alias_table_sampler_tb: done, errors");
    $finish;
  end

endmodule
